// ===== hw/rtl/weighted_mean_filter_registers_defines.svh =====
// Assertion macros for the weighted mean filter RTL.
// Included by the top level; no other dependencies.
`ifndef WEIGHTED_MEAN_FILTER_REGISTERS_DEFINES_SVH
`define WEIGHTED_MEAN_FILTER_REGISTERS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is asserted (active low)
`define WMF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("weighted mean filter check failed");
// Clocked property checked at every edge, reset included
`define WMF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("weighted mean filter check failed");
`else
`define WMF_ASSERT(label, clk, rst_n, prop)
`define WMF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/wmf_pkg.sv =====
// Shared types, constants and helper functions for the weighted mean filter.
// No dependencies.
`default_nettype none

package wmf_pkg;

    localparam int CHANNELS        = 3;
    localparam int WINDOW_SIDE     = 3;
    localparam int WINDOW_SAMPLES  = WINDOW_SIDE * WINDOW_SIDE;
    localparam int WINDOW_CENTER   = WINDOW_SAMPLES / 2;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 12;
    localparam int POS_W  = 4;
    localparam int CMD_W  = 3;

    // floor(s / 10) as (s * 6554) >> 16, exact for every 12-bit s
    localparam int DIVISOR   = 10;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int DIV_PROD_W = SUM_W + DIV_SHIFT - 2;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = CHANNELS * BYTE_W;
    localparam int M_TUSER_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_COUNT   = 3'd2,
        CMD_INVALID = 3'd3,
        CMD_IGNORE  = 3'd4
    } t_cmd;

    // Window weights: center sample counts twice
    function automatic logic [1:0] f_weight(input logic [POS_W-1:0] pos);
        if (pos == POS_W'(WINDOW_CENTER)) begin
            return 2'd2;
        end else if (pos < POS_W'(WINDOW_SAMPLES)) begin
            return 2'd1;
        end else begin
            return 2'd0;
        end
    endfunction

    // Divide by ten through a reciprocal multiply, keep the low byte
    function automatic logic [BYTE_W-1:0] f_div10(input logic [SUM_W-1:0] s);
        logic [DIV_PROD_W-1:0] prod;
        prod = DIV_PROD_W'(s) * DIV_PROD_W'(DIV_RECIP);
        return prod[DIV_SHIFT +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/weighted_mean_filter_registers.sv =====
// Top level of the register-mapped 3x3 weighted mean filter for RGB samples.
// Depends on wmf_pkg and weighted_mean_filter_registers_defines.svh.
`default_nettype none
`include "weighted_mean_filter_registers_defines.svh"

// One request enters per clock while s_tready is high and produces exactly one
// response. A request is taken into an input register at its accepting edge,
// decoded and applied to the channel state once the response register is free or
// draining (weighted accumulate, divide by ten through a reciprocal multiply,
// queue push or pop), and lands in the response register together with the
// queue memory read data, from where it is offered on m_tvalid. Each
// channel owns a QUEUE_DEPTH x 8 result memory with one write and one registered
// read port; the memory read register doubles as the response data register.
// Throughput is one request per cycle as long as m_tready stays high. While a
// response waits with m_tready low, an empty input register still takes one
// more request; s_tready drops only when both registers are full and m_tready
// is low, and that path from m_tready to s_tready is combinational.
module weighted_mean_filter_registers #(
    parameter int QUEUE_DEPTH = wmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [0] red_enable, [1] green_enable, [2] blue_enable, [10:3] red_in,
    // [18:11] green_in, [26:19] blue_in, [31:27] zero
    input  wire logic [wmf_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] command
    input  wire logic [wmf_pkg::S_TUSER_W-1:0] s_tuser,
    // Response stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [wmf_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] response, [1] underflow, [2] overflow
    output logic [wmf_pkg::M_TUSER_W-1:0]      m_tuser
);
    import wmf_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return IDX_W'(i + 1'b1);
        end
    endfunction

    // Input register
    logic                  r_a_valid;
    t_cmd                  r_a_cmd;
    logic [CHANNELS-1:0]   r_a_en;
    logic [BYTE_W-1:0]     r_a_px [CHANNELS];

    // Channel state
    logic [SUM_W-1:0]      r_sum   [CHANNELS];
    logic [POS_W-1:0]      r_pos   [CHANNELS];
    logic [CNT_W-1:0]      r_count [CHANNELS];
    logic [IDX_W-1:0]      r_head  [CHANNELS];
    logic [IDX_W-1:0]      r_tail  [CHANNELS];

    // Response register
    logic                  r_b_valid;
    logic                  r_b_resp;
    logic                  r_b_under;
    logic                  r_b_over;
    logic [CHANNELS-1:0]   r_b_pop;
    logic [BYTE_W-1:0]     r_b_data [CHANNELS];
    logic [BYTE_W-1:0]     r_rd     [CHANNELS];

    logic                  adv;
    logic                  fire;
    logic [CHANNELS-1:0]   ch_drop;
    logic [CHANNELS-1:0]   ch_pop;
    logic [CHANNELS-1:0]   ch_empty;
    logic [BYTE_W-1:0]     ch_cnt_sat [CHANNELS];

    logic                  n_b_resp;
    logic                  n_b_under;
    logic                  n_b_over;
    logic [CHANNELS-1:0]   n_b_pop;
    logic [BYTE_W-1:0]     n_b_data [CHANNELS];

    // Pipeline advances whenever the response slot is free or being drained
    assign adv      = !r_b_valid || m_tready;
    assign fire     = adv && r_a_valid;
    assign s_tready = !r_a_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            r_a_cmd   <= t_cmd'(s_tuser[CMD_W-1:0]);
            r_a_en    <= s_tdata[CHANNELS-1:0];
            r_a_px[0] <= s_tdata[3 +: BYTE_W];
            r_a_px[1] <= s_tdata[11 +: BYTE_W];
            r_a_px[2] <= s_tdata[19 +: BYTE_W];
        end
    end

    // Per-channel window accumulator and result queue
    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        logic [1:0]            wt;
        logic [BYTE_W+1:0]     prod;
        logic [SUM_W-1:0]      sum_acc;
        logic [BYTE_W-1:0]     quot;
        logic                  last;
        logic                  full;
        logic                  sample;
        logic                  push;
        logic [8:0]            cnt_ext;
        logic [BYTE_W-1:0]     r_mem [QUEUE_DEPTH];

        always_comb begin
            wt      = f_weight(r_pos[c]);
            prod    = (BYTE_W+2)'(r_a_px[c]) * (BYTE_W+2)'(wt);
            sum_acc = SUM_W'({1'b0, r_sum[c]} + (SUM_W+1)'(prod));
            quot    = f_div10(sum_acc);
            last    = (r_pos[c] >= POS_W'(WINDOW_SAMPLES - 1));
            full    = (r_count[c] == CNT_W'(QUEUE_DEPTH));
            sample  = fire && (r_a_cmd == CMD_WRITE) && r_a_en[c];
            push    = sample && last && !full;
            cnt_ext = 9'(r_count[c]);
        end

        assign ch_drop[c]    = sample && last && full;
        assign ch_empty[c]   = (r_count[c] == '0);
        assign ch_pop[c]     = fire && (r_a_cmd == CMD_READ) && !ch_empty[c];
        assign ch_cnt_sat[c] = (cnt_ext > 9'd255) ? 8'hff : cnt_ext[BYTE_W-1:0];

        // Window and queue pointer state
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[c]   <= '0;
                r_pos[c]   <= '0;
                r_count[c] <= '0;
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
            end else begin
                if (sample) begin
                    r_sum[c] <= last ? '0 : sum_acc;
                    r_pos[c] <= last ? '0 : POS_W'(r_pos[c] + 1'b1);
                end
                if (push) begin
                    r_tail[c]  <= f_next(r_tail[c]);
                    r_count[c] <= CNT_W'(r_count[c] + 1'b1);
                end else if (ch_pop[c]) begin
                    r_head[c]  <= f_next(r_head[c]);
                    r_count[c] <= CNT_W'(r_count[c] - 1'b1);
                end
            end
        end

        // Result memory: one write, one registered read
        always_ff @(posedge i_clk) begin
            if (push) begin
                r_mem[r_tail[c]] <= quot;
            end
            if (ch_pop[c]) begin
                r_rd[c] <= r_mem[r_head[c]];
            end
        end
    end

    // Response decode
    always_comb begin
        n_b_resp  = 1'b0;
        n_b_under = 1'b0;
        n_b_over  = 1'b0;
        n_b_pop   = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_b_data[c] = '0;
        end
        case (r_a_cmd)
            CMD_WRITE: begin
                n_b_over = |ch_drop;
            end
            CMD_READ: begin
                n_b_under = |ch_empty;
                n_b_pop   = ch_pop;
            end
            CMD_COUNT: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    n_b_data[c] = ch_cnt_sat[c];
                end
            end
            CMD_INVALID: begin
                n_b_resp = 1'b0;
            end
            default: begin
                n_b_resp = 1'b1;
            end
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
        if (fire) begin
            r_b_resp  <= n_b_resp;
            r_b_under <= n_b_under;
            r_b_over  <= n_b_over;
            r_b_pop   <= n_b_pop;
            r_b_data  <= n_b_data;
        end
    end

    // Popped bytes come straight from the memory read registers
    assign m_tvalid = r_b_valid;
    assign m_tuser  = {r_b_over, r_b_under, r_b_resp};
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            m_tdata[c*BYTE_W +: BYTE_W] = r_b_pop[c] ? r_rd[c] : r_b_data[c];
        end
    end

    // Checks
    `WMF_ASSERT(a_count_bound, i_clk, i_rst_n,
        (r_count[0] <= CNT_W'(QUEUE_DEPTH)) && (r_count[1] <= CNT_W'(QUEUE_DEPTH)) &&
        (r_count[2] <= CNT_W'(QUEUE_DEPTH)))
    `WMF_ASSERT(a_empty_ptrs, i_clk, i_rst_n,
        ((r_count[0] != '0) || (r_head[0] == r_tail[0])) &&
        ((r_count[1] != '0) || (r_head[1] == r_tail[1])) &&
        ((r_count[2] != '0) || (r_head[2] == r_tail[2])))
    `WMF_ASSERT(a_error_zero, i_clk, i_rst_n,
        (m_tvalid && m_tuser[0]) |-> ((m_tdata == '0) && (m_tuser[2:1] == 2'b00)))
    `WMF_ASSERT_ALWAYS(a_pos_bound, i_clk,
        (r_pos[0] < POS_W'(WINDOW_SAMPLES)) || !i_rst_n || $isunknown(r_pos[0]))

endmodule

`default_nettype wire

// ===== test/wmf_response_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the weighted mean filter: mirrors the filter state,
// predicts one response per request and compares it with the response stream.
// Depends on wmf_pkg.
module wmf_response_checker #(
    parameter int QUEUE_DEPTH = wmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    // [0] red_enable, [1] green_enable, [2] blue_enable, [10:3] red_in,
    // [18:11] green_in, [26:19] blue_in, [31:27] zero
    input  wire logic [wmf_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [2:0] command
    input  wire logic [wmf_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    input  wire logic [wmf_pkg::M_TDATA_W-1:0] i_m_tdata,
    // [0] response, [1] underflow, [2] overflow
    input  wire logic [wmf_pkg::M_TUSER_W-1:0] i_m_tuser,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    import wmf_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int COUNT_MAX    = 255;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              err;
        logic              under;
        logic              over;
    } filter_response_t;

    // Mirrored channel state
    logic [SUM_W-1:0]  win_sum   [CHANNELS];
    int                win_pos   [CHANNELS];
    logic [BYTE_W-1:0] fifo_mem  [CHANNELS][QUEUE_DEPTH];
    int                fifo_count[CHANNELS];
    int                fifo_head [CHANNELS];
    int                fifo_tail [CHANNELS];

    filter_response_t expected_responses[$];

    function automatic int wrap_index(input int idx);
        return (idx + 1 >= QUEUE_DEPTH) ? 0 : idx + 1;
    endfunction

    // Applies one request to the mirrored state and returns its response
    function automatic filter_response_t apply_request(
        input logic [S_TUSER_W-1:0] cmd,
        input logic [S_TDATA_W-1:0] payload
    );
        filter_response_t  rsp;
        logic [BYTE_W-1:0] lane [CHANNELS];
        logic [BYTE_W-1:0] sample;
        int                weight;
        rsp = '0;
        for (int c = 0; c < CHANNELS; c++) lane[c] = '0;
        case (cmd)
            CMD_WRITE: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (payload[c]) begin
                        sample = payload[CHANNELS + BYTE_W*c +: BYTE_W];
                        weight = (win_pos[c] == WINDOW_CENTER) ? 2 : 1;
                        win_sum[c] = win_sum[c] + SUM_W'(sample * weight);
                        win_pos[c]++;
                        // window complete: push or drop the mean
                        if (win_pos[c] >= WINDOW_SAMPLES) begin
                            if (fifo_count[c] >= QUEUE_DEPTH) begin
                                rsp.over = 1'b1;
                            end else begin
                                fifo_mem[c][fifo_tail[c]] = BYTE_W'(win_sum[c] / DIVISOR);
                                fifo_tail[c] = wrap_index(fifo_tail[c]);
                                fifo_count[c]++;
                            end
                            win_sum[c] = '0;
                            win_pos[c] = 0;
                        end
                    end
                end
            end
            CMD_READ: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (fifo_count[c] == 0) begin
                        rsp.under = 1'b1;
                    end else begin
                        lane[c] = fifo_mem[c][fifo_head[c]];
                        fifo_head[c] = wrap_index(fifo_head[c]);
                        fifo_count[c]--;
                    end
                end
            end
            CMD_COUNT: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    lane[c] = BYTE_W'((fifo_count[c] > COUNT_MAX) ? COUNT_MAX : fifo_count[c]);
                end
            end
            CMD_INVALID: begin
                // OK with zero data
            end
            default: begin
                rsp.err = 1'b1;
            end
        endcase
        rsp.red   = lane[0];
        rsp.green = lane[1];
        rsp.blue  = lane[2];
        return rsp;
    endfunction

    // Compare responses, then predict for newly accepted requests
    always @(posedge i_clk) begin
        filter_response_t got;
        filter_response_t want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                win_sum[c]    = '0;
                win_pos[c]    = 0;
                fifo_count[c] = 0;
                fifo_head[c]  = 0;
                fifo_tail[c]  = 0;
            end
            expected_responses.delete();
            o_mismatches <= 0;
            o_pending    <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{red: i_m_tdata[7:0], green: i_m_tdata[15:8],
                        blue: i_m_tdata[23:16], err: i_m_tuser[0],
                        under: i_m_tuser[1], over: i_m_tuser[2]};
                if (expected_responses.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT) begin
                        $display("[%0t] response with no request outstanding: %p", $realtime, got);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_responses.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.err !== want.err ||
                        got.under !== want.under || got.over !== want.over) begin
                        if (o_mismatches < REPORT_LIMIT) begin
                            $display("[%0t] response differs: expected %p, actual %p",
                                     $realtime, want, got);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_responses.push_back(apply_request(i_s_tuser, i_s_tdata));
            end
            o_pending <= expected_responses.size();
        end
    end

endmodule

// ===== test/tb_weighted_mean_filter_registers.sv =====
`timescale 1ns / 1ps
// Top of the weighted mean filter testbench: clock, reset, request and
// response drivers, verdict. Depends on wmf_pkg, the filter and wmf_response_checker.
module tb_weighted_mean_filter_registers;
    import wmf_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int PHASE_ITEMS    = 560;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [CMD_W-1:0] CMD_LAST_BAD = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    int mismatch_count;
    int pending_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    bit stall_go;

    weighted_mean_filter_registers dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    wmf_response_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_mismatches(mismatch_count),
        .o_pending   (pending_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Response side: random back-pressure plus a single long hold-off when requested
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_go) begin
                stall_left = LONG_STALL;
                stall_go   = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request, with random gaps ahead of it, until it is taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [2:0] en,
                                input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, blue, green, red, en};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Hold the request side until every response has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [7:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 8'h00;
        if (r < 10) return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    // Command mix driven by how often the current episode reads results
    function automatic logic [CMD_W-1:0] pick_command(input int read_pct);
        int r;
        r = $urandom_range(99);
        if (r < read_pct)      return CMD_READ;
        if (r < read_pct + 8)  return CMD_COUNT;
        if (r < read_pct + 11) return CMD_INVALID;
        if (r < read_pct + 13) return CMD_IGNORE;
        if (r < read_pct + 16) return CMD_W'($urandom_range(CMD_LAST_BAD, CMD_IGNORE + 1));
        return CMD_WRITE;
    endfunction

    // Random traffic in episodes that fill, drain or balance the result queues
    task automatic random_phase(input int items, input bit with_stall);
        int               sent;
        int               episode_left;
        int               read_pct;
        int               mode;
        logic [CMD_W-1:0] cmd;
        logic [2:0]       en;
        sent         = 0;
        episode_left = 0;
        read_pct     = 10;
        while (sent < items) begin
            if (episode_left == 0) begin
                mode = $urandom_range(2);
                case (mode)
                    0: begin read_pct = 2;  episode_left = $urandom_range(250, 150); end
                    1: begin read_pct = 35; episode_left = $urandom_range(120, 40);  end
                    default: begin read_pct = 10; episode_left = $urandom_range(120, 40); end
                endcase
            end
            if (with_stall && sent == 100) begin
                @(negedge i_clk);
                stall_go = 1'b1;
            end
            cmd = pick_command(read_pct);
            en  = ($urandom_range(99) < 75) ? 3'b111 : 3'($urandom_range(7));
            send_request(cmd, en, pick_sample(), pick_sample(), pick_sample());
            sent++;
            episode_left--;
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_INVALID;
        stall_go      = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 46;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queues, non-data commands
        send_request(CMD_READ, 3'b000, 8'h00, 8'h00, 8'h00);
        send_request(CMD_COUNT, 3'b111, 8'hff, 8'hff, 8'hff);
        send_request(CMD_INVALID, 3'b111, 8'hff, 8'hff, 8'hff);
        send_request(CMD_IGNORE, 3'b111, 8'hff, 8'hff, 8'hff);
        for (int b = CMD_IGNORE + 1; b <= CMD_LAST_BAD; b++) begin
            send_request(CMD_W'(b), 3'b111, 8'hff, 8'hff, 8'hff);
        end
        // Full-scale window; blue skipped on the first pixel, so it lags by one
        send_request(CMD_WRITE, 3'b011, 8'hff, 8'hff, 8'hff);
        for (int k = 1; k < WINDOW_SAMPLES; k++) begin
            send_request(CMD_WRITE, 3'b111, 8'hff, 8'hff, 8'hff);
        end
        send_request(CMD_COUNT, 3'b000, 8'h00, 8'h00, 8'h00);
        // Red and green pop, blue queue empty
        send_request(CMD_READ, 3'b000, 8'h00, 8'h00, 8'h00);
        // Write with nothing enabled leaves every window alone
        send_request(CMD_WRITE, 3'b000, 8'h00, 8'h00, 8'h00);
        // Blue completes with a zero sample
        send_request(CMD_WRITE, 3'b100, 8'hff, 8'hff, 8'h00);
        send_request(CMD_COUNT, 3'b000, 8'h00, 8'h00, 8'h00);
        send_request(CMD_READ, 3'b000, 8'h00, 8'h00, 8'h00);
        send_request(CMD_READ, 3'b000, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Random phases: sender-light/receiver-heavy, swapped, then no idling
        random_phase(PHASE_ITEMS, 1'b1);
        wait_drained();
        @(negedge i_clk);
        send_idle_pct = 46;
        recv_idle_pct = 31;
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drained();
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_ITEMS, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wmf_pkg.sv
hw/rtl/weighted_mean_filter_registers.sv
test/wmf_response_checker.sv
test/tb_weighted_mean_filter_registers.sv
